@@ hdl/jacobi_symbol_top_defines.svh @@
// ----------------------------------------------------------------------------
// Jacobi symbol unit - assertion macros
// Shared concurrent assertion forms for the Jacobi symbol sequencer.
// ----------------------------------------------------------------------------
`ifndef JACOBI_SYMBOL_TOP_DEFINES_SVH
`define JACOBI_SYMBOL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JAC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JAC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/jac_pkg.sv @@
// ----------------------------------------------------------------------------
// Jacobi symbol package
// Control word type, step, condition and operation codes, microprogram ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

  localparam int IN_FIELD_W = 32;
  localparam int STEP_W     = 3;
  localparam int COND_W     = 3;
  localparam int OP_W       = 3;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [COND_W-1:0] cond_t;
  typedef logic [OP_W-1:0]   op_t;

  typedef struct packed {
    cond_t cond;
    op_t   op;
    step_t tgt;
  } ctrl_t;

  // Program steps
  localparam step_t S_CHECK = 3'd0;
  localparam step_t S_TESTA = 3'd1;
  localparam step_t S_EVEN  = 3'd2;
  localparam step_t S_RED   = 3'd3;
  localparam step_t S_WAIT  = 3'd4;
  localparam step_t S_EMIT  = 3'd5;
  localparam step_t S_SPARE = 3'd6;
  localparam step_t S_IDLE  = 3'd7;

  // Jump conditions
  localparam cond_t C_ALWAYS   = 3'd0;
  localparam cond_t C_N_EVEN   = 3'd1;
  localparam cond_t C_A_ZERO   = 3'd2;
  localparam cond_t C_A_EVEN   = 3'd3;
  localparam cond_t C_OUT_BUSY = 3'd4;

  // Datapath operations
  localparam op_t OP_NOP     = 3'd0;
  localparam op_t OP_SET_BAD = 3'd1;
  localparam op_t OP_HALVE   = 3'd2;
  localparam op_t OP_REDUCE  = 3'd3;
  localparam op_t OP_EMIT    = 3'd4;

  // Symbol codes, two's complement
  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  // Microprogram: when the condition holds, run op and jump to tgt,
  // otherwise fall through to the next step.
  function automatic ctrl_t rom_word(input step_t step);
    ctrl_t w;
    unique case (step)
      S_CHECK: w = '{cond: C_N_EVEN,   op: OP_SET_BAD, tgt: S_WAIT};
      S_TESTA: w = '{cond: C_A_ZERO,   op: OP_NOP,     tgt: S_WAIT};
      S_EVEN:  w = '{cond: C_A_EVEN,   op: OP_HALVE,   tgt: S_EVEN};
      S_RED:   w = '{cond: C_ALWAYS,   op: OP_REDUCE,  tgt: S_TESTA};
      S_WAIT:  w = '{cond: C_OUT_BUSY, op: OP_NOP,     tgt: S_WAIT};
      S_EMIT:  w = '{cond: C_ALWAYS,   op: OP_EMIT,    tgt: S_IDLE};
      S_SPARE: w = '{cond: C_ALWAYS,   op: OP_NOP,     tgt: S_IDLE};
      S_IDLE:  w = '{cond: C_ALWAYS,   op: OP_NOP,     tgt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/jacobi_symbol_top.sv @@
// Result timing is data dependent: out_tvalid rises soonest for an even or zero
//   modulus; otherwise it is set by the one-step-per-cycle microprogram loop, plus
//   any wait for the output register.
// Flow: one item in flight; the next input transaction is taken once the
//   result sits in the output register.
// Reset: synchronous, active low; sets the step counter to idle and clears output valid.
// ----------------------------------------------------------------------------
// Jacobi symbol unit
// Microcoded binary Jacobi symbol (a/n) of an unsigned numerator over an
// odd modulus, with a flag for an even or zero modulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "jacobi_symbol_top_defines.svh"

module jacobi_symbol_top #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] numerator, [63:32] modulus
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [1:0] symbol, [7:2] zero
  output logic [0:0]       out_tuser   // [0] bad_modulus
);

  // Step counter and current control word
  jac_pkg::step_t pc_r, pc_nxt;
  jac_pkg::ctrl_t cw;
  logic           cond_true;

  // Datapath registers
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;
  logic             neg_r, neg_nxt;
  logic             bad_r, bad_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [1:0]       out_sym_r, out_sym_nxt;
  logic                    out_bad_r, out_bad_nxt;

  logic in_acc;
  logic a_lt_n;
  logic [WIDTH-1:0] diff;

  assign cw        = jac_pkg::rom_word(pc_r);
  assign in_tready = (pc_r == jac_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // One compare per reduction step; it picks which of the two differences is used
  assign a_lt_n = (a_r < n_r);
  assign diff   = a_lt_n ? (n_r - a_r) : (a_r - n_r);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (cw.cond)
      jac_pkg::C_ALWAYS:   cond_true = 1'b1;
      jac_pkg::C_N_EVEN:   cond_true = !n_r[0];
      jac_pkg::C_A_ZERO:   cond_true = (a_r == '0);
      jac_pkg::C_A_EVEN:   cond_true = !a_r[0];
      jac_pkg::C_OUT_BUSY: cond_true = out_valid_r && !out_tready;
      default:             cond_true = 1'b0;
    endcase
  end

  // Datapath and sequencing
  always_comb begin
    pc_nxt        = cond_true ? cw.tgt : jac_pkg::step_t'(pc_r + 1'b1);
    a_nxt         = a_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    bad_nxt       = bad_r;
    out_sym_nxt   = out_sym_r;
    out_bad_nxt   = out_bad_r;
    // Drop the output once the downstream side takes it
    out_valid_nxt = out_valid_r && !out_tready;

    if (cond_true) begin
      unique case (cw.op)
        jac_pkg::OP_SET_BAD: bad_nxt = 1'b1;
        jac_pkg::OP_HALVE: begin
          // Each factor of two flips the sign when n is 3 or 5 mod 8
          a_nxt = a_r >> 1;
          if (n_r[2:0] == 3'd3 || n_r[2:0] == 3'd5) begin
            neg_nxt = !neg_r;
          end
        end
        jac_pkg::OP_REDUCE: begin
          // Both odd here; swap (with reciprocity) when a < n, then subtract
          a_nxt = diff;
          if (a_lt_n) begin
            n_nxt = a_r;
            if (a_r[1:0] == 2'd3 && n_r[1:0] == 2'd3) begin
              neg_nxt = !neg_r;
            end
          end
        end
        jac_pkg::OP_EMIT: begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          if (!bad_r && n_r == WIDTH'(1)) begin
            out_sym_nxt = neg_r ? jac_pkg::SYM_NEG : jac_pkg::SYM_POS;
          end else begin
            out_sym_nxt = jac_pkg::SYM_ZERO;
          end
        end
        default: ;
      endcase
    end

    // Load a new transaction and restart the program
    if (in_acc) begin
      a_nxt   = WIDTH'(in_tdata[jac_pkg::IN_FIELD_W-1:0]);
      n_nxt   = WIDTH'(in_tdata[2*jac_pkg::IN_FIELD_W-1:jac_pkg::IN_FIELD_W]);
      neg_nxt = 1'b0;
      bad_nxt = 1'b0;
      pc_nxt  = jac_pkg::S_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= jac_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    n_r       <= n_nxt;
    neg_r     <= neg_nxt;
    bad_r     <= bad_nxt;
    out_sym_r <= out_sym_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_sym_r};
  assign out_tuser  = out_bad_r;

  // Emit only into a free output register
  `JAC_ASSERT_IMP(a_emit_free, clk, rst_n, pc_r == jac_pkg::S_EMIT, !out_valid_r,
                  "emit over pending result")
  // Modulus stays odd through the reduction loop
  `JAC_ASSERT_IMP(a_n_odd, clk, rst_n,
                  (pc_r == jac_pkg::S_TESTA || pc_r == jac_pkg::S_EVEN ||
                   pc_r == jac_pkg::S_RED),
                  n_r[0], "modulus went even in loop")
  // A flagged modulus always carries a zero symbol
  `JAC_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid_r && out_bad_r,
                  out_sym_r == jac_pkg::SYM_ZERO, "bad modulus with nonzero symbol")
  // An accepted transaction starts the program at the modulus check
  `JAC_ASSERT_NXT(a_start, clk, rst_n, in_acc,
                  pc_r == jac_pkg::S_CHECK && !bad_r && !neg_r, "program did not restart")

endmodule

`default_nettype wire

@@ test/jacobi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi symbol checker
// Watches both stream channels of the Jacobi symbol unit. For every input
// transaction it computes the expected symbol and bad-modulus flag and
// queues the result. It compares each result transaction field by field
// with the oldest queued entry and keeps a count of failures and tallies.
// ----------------------------------------------------------------------------
module jacobi_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] numerator, [63:32] modulus
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [1:0] symbol, [7:2] zero
  input  logic [0:0]  out_tuser,  // [0] bad_modulus
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          neg_count,
  output int          zero_count,
  output int          bad_count
);

  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [5:0]        pad;
    logic signed [1:0] symbol;
    logic              bad;
  } jac_result_t;

  jac_result_t symbol_due_q [$];
  jac_result_t got;
  jac_result_t want;
  int          n_fail    = 0;
  int          n_checked = 0;
  int          n_neg     = 0;
  int          n_zero    = 0;
  int          n_bad     = 0;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    neg_count     = 0;
    zero_count    = 0;
    bad_count     = 0;
  end

  // Modulo-based Jacobi method on 32-bit operands: reduce, strip twos, swap.
  function automatic jac_result_t jacobi_of(input logic [31:0] num,
                                            input logic [31:0] modv);
    logic [31:0] a;
    logic [31:0] n;
    logic [31:0] t;
    logic        flip;
    jac_result_t r;
    r    = '0;
    flip = 1'b0;
    // An even modulus (zero included) is flagged and gives symbol zero
    if (modv[0] == 1'b0) begin
      r.bad = 1'b1;
      return r;
    end
    a = num % modv;
    n = modv;
    while (a != 0) begin
      while (a[0] == 1'b0) begin
        a = a >> 1;
        // (2/n) is -1 exactly when n is 3 or 5 mod 8
        if (n[2:0] == 3'd3 || n[2:0] == 3'd5)
          flip = ~flip;
      end
      t = a;
      a = n;
      n = t;
      // Reciprocity: flip when both are 3 mod 4
      if (a[1:0] == 2'b11 && n[1:0] == 2'b11)
        flip = ~flip;
      a = a % n;
    end
    // A final modulus above one means a common factor
    if (n == 1)
      r.symbol = flip ? jac_pkg::SYM_NEG : jac_pkg::SYM_POS;
    else
      r.symbol = jac_pkg::SYM_ZERO;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Drain the result side first; one item in flight keeps order trivial
      if (out_tvalid && out_tready) begin
        got.pad    = out_tdata[7:2];
        got.symbol = out_tdata[1:0];
        got.bad    = out_tuser[0];
        if (symbol_due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected result transaction: symbol %0d, bad_modulus %0b",
                     $time, got.symbol, got.bad);
        end else begin
          want = symbol_due_q.pop_front();
          n_checked++;
          if (got.symbol != want.symbol)
            report_mismatch("symbol", want.symbol, got.symbol);
          if (got.bad != want.bad)
            report_mismatch("bad_modulus", want.bad, got.bad);
          if (got.pad != want.pad)
            report_mismatch("tdata padding", want.pad, got.pad);
          if (want.bad)
            n_bad++;
          else if (want.symbol == jac_pkg::SYM_NEG)
            n_neg++;
          else if (want.symbol == jac_pkg::SYM_ZERO)
            n_zero++;
        end
      end
      if (in_tvalid && in_tready)
        symbol_due_q.push_back(jacobi_of(in_tdata[31:0], in_tdata[63:32]));
    end
    fail_count    <= n_fail;
    pending       <= symbol_due_q.size();
    checked_count <= n_checked;
    neg_count     <= n_neg;
    zero_count    <= n_zero;
    bad_count     <= n_bad;
  end

endmodule

@@ test/tb_jacobi_symbol_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi symbol unit testbench
// Drives numerator/modulus pairs into the unit in random bursts, first a
// directed set of edge cases and then weighted random pairs, while the
// result side stalls on a changing pattern. A checker beside the unit
// predicts every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_jacobi_symbol_top;

  localparam int RANDOM_ITEMS = 1500;
  // Settle margin after the last drain; allow generously for stalls
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 4000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] numerator, [63:32] modulus
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [1:0] symbol, [7:2] zero
  logic [0:0]  out_tuser;         // [0] bad_modulus

  int fail_count;
  int pending;
  int checked_count;
  int neg_count;
  int zero_count;
  int bad_count;

  int          items_sent  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  logic [9:0]  rx_phase    = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  jacobi_symbol_top #(.WIDTH(32)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  jacobi_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .neg_count     (neg_count),
    .zero_count    (zero_count),
    .bad_count     (bad_count)
  );

  // Result-side back-pressure: rotate through four moods on the top bits of rx_phase -
  // always ready, mostly ready, long regular stalls, and coin-toss.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= (rx_phase[5:4] != 2'd0);
      default: out_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Watchdog: end the run when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Send one pair. Open a new burst, with a random gap, when the old one is
  // spent; keep tvalid high between transactions inside a burst.
  task automatic feed_item(input logic [31:0] num, input logic [31:0] modv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {modv, num};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Hold off the input until every queued result has been taken
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Weighted random pair: mostly well-formed odd moduli, plus common-factor
  // pairs, unit and tiny moduli, powers of two and even moduli.
  task automatic pick_random(output logic [31:0] num, output logic [31:0] modv);
    int          kind;
    logic [31:0] g;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      num  = $urandom;
      modv = $urandom | 32'd1;
    end else if (kind < 58) begin
      num  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 300);
      modv = $urandom_range(0, 127) * 2 + 1;
    end else if (kind < 73) begin
      // Shared odd factor forces a zero symbol
      g    = $urandom_range(1, 49) * 2 + 1;
      num  = g * $urandom_range(0, 50000);
      modv = g * ($urandom_range(0, 20000) * 2 + 1);
    end else if (kind < 78) begin
      num  = $urandom;
      modv = 32'd1;
    end else if (kind < 86) begin
      num  = 32'd1 << $urandom_range(0, 31);
      modv = $urandom | 32'd1;
    end else if (kind < 96) begin
      num  = $urandom;
      modv = ($urandom_range(0, 7) == 0) ? 32'd0 : ($urandom & ~32'd1);
    end else begin
      // Numerator above the modulus, always near the top of the range
      modv = $urandom_range(1, 65535) * 2 + 1;
      num  = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    end
  endtask

  initial begin
    logic [31:0] num;
    logic [31:0] modv;
    int          idx;

    // Synchronous reset, held low at the start
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edge cases
    feed_item(32'd0,          32'd1);           // zero over unit modulus
    feed_item(32'd0,          32'd3);           // zero over modulus above one
    feed_item(32'd0,          32'hFFFF_FFFF);
    feed_item(32'hFFFF_FFFF,  32'hFFFF_FFFF);   // equal operands share a factor
    feed_item(32'hFFFF_FFFF,  32'd1);           // unit modulus, largest numerator
    feed_item(32'd1,          32'd1);
    feed_item(32'd5,          32'd0);           // zero modulus
    feed_item(32'd0,          32'd0);
    feed_item(32'd7,          32'd2);           // even modulus
    feed_item(32'hFFFF_FFFF,  32'hFFFF_FFFE);
    feed_item(32'd1,          32'hFFFF_FFFF);
    feed_item(32'd2,          32'd7);           // two over 7 mod 8: plus one
    feed_item(32'd2,          32'd3);           // two over 3 mod 8: minus one
    feed_item(32'd2,          32'd5);           // two over 5 mod 8: minus one
    feed_item(32'd3,          32'd7);           // reciprocity flip
    feed_item(32'd15,         32'd21);          // common factor
    feed_item(32'd8,          32'd21);
    feed_item(32'd19,         32'd45);
    feed_item(32'h8000_0000,  32'hFFFF_FFFB);   // many halvings, prime modulus
    feed_item(32'hFFFF_FFFE,  32'hFFFF_FFFB);
    feed_item(32'hAAAA_AAAA,  32'h5555_5555);
    feed_item(32'd12345678,   32'h8000_0001);
    feed_item(32'd1001,       32'd9907);
    feed_item(32'h7FFF_FFFF,  32'd3);
    drain_results();

    // Weighted random part, with one full drain half way
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      pick_random(num, modv);
      feed_item(num, modv);
      if (idx == RANDOM_ITEMS / 2)
        drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d pairs sent, %0d results checked", items_sent, checked_count);
    $display("Summary: %0d gave -1, %0d gave 0, %0d had an even or zero modulus",
             neg_count, zero_count, bad_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
